[sv/proximity_trend_alert_unit_macros.svh]
// Assertion macros for the proximity trend alert unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PROXIMITY_TREND_ALERT_UNIT_MACROS_SVH
`define PROXIMITY_TREND_ALERT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked in the same cycle
`define PTA_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Implication checked in the next cycle
`define PTA_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define PTA_ASSERT_IMP(label, clk, rst_n, pre, post, msg)
`define PTA_ASSERT_NXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

[sv/pta_pkg.sv]
// Package for the proximity trend alert unit: types, codes, constants.
// No dependencies; used by every other file of the block except the macro header.
`default_nettype none

package pta_pkg;

  // Default field widths
  localparam int ID_BITS_DEF   = 10;
  localparam int DIST_BITS_DEF = 20;

  // Configuration port
  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 3;

  // Timing and trend constants
  localparam logic [31:0] FAR_START     = 32'd999999;
  localparam logic [31:0] STEP_SHORT_MS = 32'd120;
  localparam logic [31:0] STEP_LONG_MS  = 32'd140;
  localparam logic [1:0]  CONFIRM_COUNT = 2'd2;
  localparam logic [1:0]  COUNT_MAX     = 2'd3;

  // Enable bit positions
  localparam int EN_ALARM  = 0;
  localparam int EN_SIREN  = 1;
  localparam int EN_BEEPER = 2;

  // Register reset values
  localparam logic [15:0] ALARM_DIST_RST = 16'd500;
  localparam logic [15:0] DEPART_CLR_RST = 16'd600;
  localparam logic [9:0]  EPSILON_RST    = 10'd10;
  localparam logic [31:0] HOLD_RST       = 32'd2000;
  localparam logic [31:0] CLEAR_RST      = 32'd3000;
  localparam logic [31:0] SIREN_IVL_RST  = 32'd10000;
  localparam logic [2:0]  ENABLE_RST     = 3'd7;

  typedef enum logic [1:0] {
    ST_INACTIVE = 2'd0,
    ST_APPROACH = 2'd1,
    ST_DEPART   = 2'd2
  } alert_state_e;

  typedef enum logic [2:0] {
    TONE_OFF  = 3'd0,
    TONE_600  = 3'd1,
    TONE_900  = 3'd2,
    TONE_1300 = 3'd3,
    TONE_1800 = 3'd4
  } tone_e;

  typedef enum logic [1:0] {
    SIREN_S0 = 2'd0,
    SIREN_S1 = 2'd1,
    SIREN_S2 = 2'd2,
    SIREN_S3 = 2'd3
  } siren_step_e;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_ALARM_DIST = 3'd0,
    REG_DEPART_CLR = 3'd1,
    REG_EPSILON    = 3'd2,
    REG_HOLD       = 3'd3,
    REG_CLEAR      = 3'd4,
    REG_SIREN_IVL  = 3'd5,
    REG_ENABLE     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] alarm_distance_m;
    logic [15:0] depart_clear_m;
    logic [9:0]  epsilon_m;
    logic [31:0] hold_ms;
    logic [31:0] clear_ms;
    logic [31:0] siren_gap_ms;
    logic [2:0]  enable_bits;
  } pta_cfg_t;

endpackage

`default_nettype wire

[sv/pta_in_if.sv]
// Input channel of the proximity trend alert unit: valid/ready plus one position item.
// Depends on pta_pkg for default widths.
`default_nettype none

interface pta_in_if #(
  parameter int ID_BITS   = pta_pkg::ID_BITS_DEF,
  parameter int DIST_BITS = pta_pkg::DIST_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 position_valid;
  logic [31:0]          now_ms;
  logic                 closest_found;
  logic [ID_BITS-1:0]   closest_id;
  logic [DIST_BITS-1:0] closest_distance_m;
  logic [DIST_BITS-1:0] tracked_distance_m;

  modport source (
    output valid, position_valid, now_ms, closest_found, closest_id,
           closest_distance_m, tracked_distance_m,
    input  ready
  );
  modport sink (
    input  valid, position_valid, now_ms, closest_found, closest_id,
           closest_distance_m, tracked_distance_m,
    output ready
  );
endinterface

`default_nettype wire

[sv/pta_out_if.sv]
// Result channel of the proximity trend alert unit: valid/ready plus one result item.
// Depends on pta_pkg for default widths.
`default_nettype none

interface pta_out_if #(
  parameter int ID_BITS   = pta_pkg::ID_BITS_DEF,
  parameter int DIST_BITS = pta_pkg::DIST_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           alert_state;
  logic                 alert_active;
  logic                 restore_needed;
  logic                 tracked_valid;
  logic [ID_BITS-1:0]   tracked_id;
  logic [DIST_BITS-1:0] shown_distance_m;
  logic [2:0]           tone_code;

  modport source (
    output valid, alert_state, alert_active, restore_needed, tracked_valid,
           tracked_id, shown_distance_m, tone_code,
    input  ready
  );
  modport sink (
    input  valid, alert_state, alert_active, restore_needed, tracked_valid,
           tracked_id, shown_distance_m, tone_code,
    output ready
  );
endinterface

`default_nettype wire

[sv/pta_regs.sv]
// APB-style configuration registers of the proximity trend alert unit.
// Depends on pta_pkg (register codes, reset values, config struct).
`default_nettype none

module pta_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pta_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [pta_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [pta_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                   pready,
  output pta_pkg::pta_cfg_t                      cfg_o
);

  pta_pkg::pta_cfg_t cfg_q;
  logic              wr_en;
  logic [pta_pkg::REG_IDX_BITS-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[pta_pkg::APB_ADDR_BITS-1:2];
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_distance_m <= pta_pkg::ALARM_DIST_RST;
      cfg_q.depart_clear_m   <= pta_pkg::DEPART_CLR_RST;
      cfg_q.epsilon_m        <= pta_pkg::EPSILON_RST;
      cfg_q.hold_ms          <= pta_pkg::HOLD_RST;
      cfg_q.clear_ms         <= pta_pkg::CLEAR_RST;
      cfg_q.siren_gap_ms     <= pta_pkg::SIREN_IVL_RST;
      cfg_q.enable_bits      <= pta_pkg::ENABLE_RST;
    end else if (wr_en) begin
      case (idx)
        pta_pkg::REG_ALARM_DIST: cfg_q.alarm_distance_m <= pwdata[15:0];
        pta_pkg::REG_DEPART_CLR: cfg_q.depart_clear_m   <= pwdata[15:0];
        pta_pkg::REG_EPSILON:    cfg_q.epsilon_m        <= pwdata[9:0];
        pta_pkg::REG_HOLD:       cfg_q.hold_ms          <= pwdata;
        pta_pkg::REG_CLEAR:      cfg_q.clear_ms         <= pwdata;
        pta_pkg::REG_SIREN_IVL:  cfg_q.siren_gap_ms     <= pwdata;
        pta_pkg::REG_ENABLE:     cfg_q.enable_bits      <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (idx)
      pta_pkg::REG_ALARM_DIST: prdata = {16'd0, cfg_q.alarm_distance_m};
      pta_pkg::REG_DEPART_CLR: prdata = {16'd0, cfg_q.depart_clear_m};
      pta_pkg::REG_EPSILON:    prdata = {22'd0, cfg_q.epsilon_m};
      pta_pkg::REG_HOLD:       prdata = cfg_q.hold_ms;
      pta_pkg::REG_CLEAR:      prdata = cfg_q.clear_ms;
      pta_pkg::REG_SIREN_IVL:  prdata = cfg_q.siren_gap_ms;
      pta_pkg::REG_ENABLE:     prdata = {29'd0, cfg_q.enable_bits};
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/pta_core.sv]
// Alert state, trend counters, away timer and siren sequencer; one update per step.
// Depends on pta_pkg and the assertion macro header.
`default_nettype none
`include "proximity_trend_alert_unit_macros.svh"

module pta_core #(
  parameter int ID_BITS   = pta_pkg::ID_BITS_DEF,
  parameter int DIST_BITS = pta_pkg::DIST_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire pta_pkg::pta_cfg_t    cfg_i,
  input  wire logic                 position_valid_i,
  input  wire logic [31:0]          now_ms_i,
  input  wire logic                 closest_found_i,
  input  wire logic [ID_BITS-1:0]   closest_id_i,
  input  wire logic [DIST_BITS-1:0] closest_distance_m_i,
  input  wire logic [DIST_BITS-1:0] tracked_distance_m_i,
  output logic [1:0]                alert_state_o,
  output logic                      alert_active_o,
  output logic                      restore_needed_o,
  output logic                      tracked_valid_o,
  output logic [ID_BITS-1:0]        tracked_id_o,
  output logic [DIST_BITS-1:0]      shown_distance_m_o,
  output logic [2:0]                tone_code_o
);

  // Start distance, clipped to the distance width
  localparam logic [63:0] DMASK64 = (64'd1 << DIST_BITS) - 64'd1;
  localparam logic [DIST_BITS-1:0] FAR_VAL =
    DIST_BITS'((64'(pta_pkg::FAR_START) > DMASK64) ? DMASK64 : 64'(pta_pkg::FAR_START));

  pta_pkg::alert_state_e state_q, state_d, ns;
  logic                  tv_q, tv_d;
  logic [ID_BITS-1:0]    idx_q, idx_d;
  logic [DIST_BITS-1:0]  prev_q, prev_d;
  logic [1:0]            near_q, near_d, far_q, far_d;
  logic [31:0]           change_q, change_d;
  logic [31:0]           siren_time_q, siren_time_d;
  logic [31:0]           away_q, away_d;
  logic                  on_q, on_d;
  pta_pkg::siren_step_e  sstep_q, sstep_d;
  logic [31:0]           due_q, due_d;
  pta_pkg::tone_e        tone_q, tone_d;

  logic                  active, restore;
  logic [DIST_BITS-1:0]  shown, check, radius, step_dist;
  logic [DIST_BITS:0]    eps_ext;
  logic                  near_move, far_move, ca, cd;
  logic [31:0]           away_age, due_gap;

  // One position update
  always_comb begin
    state_d      = state_q;
    tv_d         = tv_q;
    idx_d        = idx_q;
    prev_d       = prev_q;
    near_d       = near_q;
    far_d        = far_q;
    change_d     = change_q;
    siren_time_d = siren_time_q;
    away_d       = away_q;
    on_d         = on_q;
    sstep_d      = sstep_q;
    due_d        = due_q;
    tone_d       = tone_q;
    active       = 1'b0;
    restore      = 1'b0;
    shown        = '0;
    ns           = state_q;
    step_dist    = tracked_distance_m_i;
    eps_ext      = (DIST_BITS+1)'(cfg_i.epsilon_m);
    near_move    = 1'b0;
    far_move     = 1'b0;
    ca           = 1'b0;
    cd           = 1'b0;
    check        = tv_q ? tracked_distance_m_i : closest_distance_m_i;
    radius       = (state_q == pta_pkg::ST_DEPART) ? DIST_BITS'(cfg_i.depart_clear_m)
                                                   : DIST_BITS'(cfg_i.alarm_distance_m);
    away_age     = '0;
    due_gap      = '0;

    if (!position_valid_i || !cfg_i.enable_bits[pta_pkg::EN_ALARM] || !closest_found_i) begin
      // No fix, alarm off, or no nearest point
      if (!(position_valid_i && cfg_i.enable_bits[pta_pkg::EN_ALARM])) begin
        tone_d  = pta_pkg::TONE_OFF;
        on_d    = 1'b0;
        sstep_d = pta_pkg::SIREN_S0;
        due_d   = '0;
      end
      if (state_q != pta_pkg::ST_INACTIVE) begin
        state_d = pta_pkg::ST_INACTIVE;
        tv_d    = 1'b0;
        restore = 1'b1;
      end
      away_d = '0;
    end else if (check > radius) begin
      // Out of range: run the away timer
      away_d   = (away_q == '0) ? now_ms_i : away_q;
      away_age = now_ms_i - away_d;
      if (away_age > cfg_i.clear_ms) begin
        if (state_q != pta_pkg::ST_INACTIVE) begin
          state_d = pta_pkg::ST_INACTIVE;
          tv_d    = 1'b0;
          prev_d  = FAR_VAL;
          restore = 1'b1;
        end
        away_d = '0;
      end else if (state_q != pta_pkg::ST_INACTIVE && tv_q) begin
        active = 1'b1;
        shown  = check;
      end
    end else begin
      // In range: track, update trend, gate the change by the hold time
      away_d = '0;
      if (state_q == pta_pkg::ST_INACTIVE || !tv_q) begin
        tv_d      = 1'b1;
        idx_d     = closest_id_i;
        step_dist = closest_distance_m_i;
      end
      near_move = {1'b0, prev_q} >= ({1'b0, step_dist} + eps_ext);
      far_move  = {1'b0, step_dist} >= ({1'b0, prev_q} + eps_ext);
      if (near_move) begin
        near_d = (near_q == pta_pkg::COUNT_MAX) ? near_q : near_q + 2'd1;
        far_d  = 2'd0;
      end else if (far_move) begin
        far_d  = (far_q == pta_pkg::COUNT_MAX) ? far_q : far_q + 2'd1;
        near_d = 2'd0;
      end
      ca = near_d >= pta_pkg::CONFIRM_COUNT;
      cd = far_d >= pta_pkg::CONFIRM_COUNT;
      case (state_q)
        pta_pkg::ST_APPROACH: ns = cd ? pta_pkg::ST_DEPART : pta_pkg::ST_APPROACH;
        pta_pkg::ST_DEPART:   ns = ca ? pta_pkg::ST_APPROACH : pta_pkg::ST_DEPART;
        default: begin
          if (ca)      ns = pta_pkg::ST_APPROACH;
          else if (cd) ns = pta_pkg::ST_DEPART;
          else         ns = state_q;
        end
      endcase
      if (ns != state_q &&
          (state_q == pta_pkg::ST_INACTIVE || (now_ms_i - change_q) >= cfg_i.hold_ms)) begin
        state_d  = ns;
        change_d = now_ms_i;
        near_d   = 2'd0;
        far_d    = 2'd0;
        if (ns != pta_pkg::ST_APPROACH) begin
          tone_d  = pta_pkg::TONE_OFF;
          on_d    = 1'b0;
          sstep_d = pta_pkg::SIREN_S0;
          due_d   = '0;
        end
      end
      active = 1'b1;
      shown  = step_dist;

      // Siren restart at the interval while approaching
      if (cfg_i.enable_bits[pta_pkg::EN_SIREN] && state_d == pta_pkg::ST_APPROACH &&
          (now_ms_i - siren_time_q) >= cfg_i.siren_gap_ms) begin
        if (cfg_i.enable_bits[pta_pkg::EN_BEEPER]) begin
          on_d    = 1'b1;
          sstep_d = pta_pkg::SIREN_S0;
          due_d   = now_ms_i + pta_pkg::STEP_SHORT_MS;
          tone_d  = pta_pkg::TONE_600;
        end
        siren_time_d = now_ms_i;
      end

      // Siren step once its due time is reached
      due_gap = now_ms_i - due_d;
      if (on_d && !due_gap[31]) begin
        case (sstep_d)
          pta_pkg::SIREN_S0: begin
            tone_d  = pta_pkg::TONE_900;
            sstep_d = pta_pkg::SIREN_S1;
            due_d   = now_ms_i + pta_pkg::STEP_SHORT_MS;
          end
          pta_pkg::SIREN_S1: begin
            tone_d  = pta_pkg::TONE_1300;
            sstep_d = pta_pkg::SIREN_S2;
            due_d   = now_ms_i + pta_pkg::STEP_SHORT_MS;
          end
          pta_pkg::SIREN_S2: begin
            tone_d  = pta_pkg::TONE_1800;
            sstep_d = pta_pkg::SIREN_S3;
            due_d   = now_ms_i + pta_pkg::STEP_LONG_MS;
          end
          default: begin
            tone_d  = pta_pkg::TONE_OFF;
            on_d    = 1'b0;
            sstep_d = pta_pkg::SIREN_S0;
            due_d   = '0;
          end
        endcase
      end
      prev_d = step_dist;
    end
  end

  // State registers, updated on each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pta_pkg::ST_INACTIVE;
      tv_q         <= 1'b0;
      idx_q        <= '0;
      prev_q       <= FAR_VAL;
      near_q       <= 2'd0;
      far_q        <= 2'd0;
      change_q     <= '0;
      siren_time_q <= '0;
      away_q       <= '0;
      on_q         <= 1'b0;
      sstep_q      <= pta_pkg::SIREN_S0;
      due_q        <= '0;
      tone_q       <= pta_pkg::TONE_OFF;
    end else if (step_i) begin
      state_q      <= state_d;
      tv_q         <= tv_d;
      idx_q        <= idx_d;
      prev_q       <= prev_d;
      near_q       <= near_d;
      far_q        <= far_d;
      change_q     <= change_d;
      siren_time_q <= siren_time_d;
      away_q       <= away_d;
      on_q         <= on_d;
      sstep_q      <= sstep_d;
      due_q        <= due_d;
      tone_q       <= tone_d;
    end
  end

  // Result of this step
  assign alert_state_o      = state_d;
  assign alert_active_o     = active;
  assign restore_needed_o   = restore;
  assign tracked_valid_o    = tv_d;
  assign tracked_id_o       = idx_d;
  assign shown_distance_m_o = shown;
  assign tone_code_o        = tone_d;

  // A tone only sounds while the sequencer runs
  `PTA_ASSERT_IMP(a_tone_needs_siren, clk_i, rst_ni, tone_q != pta_pkg::TONE_OFF, on_q,
                  "tone set while siren is off")
  // Approach and depart counters never run together
  `PTA_ASSERT_IMP(a_counts_exclusive, clk_i, rst_ni, near_q != 2'd0, far_q == 2'd0,
                  "near and far counters both nonzero")
  // An idle cycle leaves the alert state alone
  `PTA_ASSERT_NXT(a_idle_holds_state, clk_i, rst_ni, !step_i, state_q == $past(state_q),
                  "alert state moved without a step")

endmodule

`default_nettype wire

[sv/proximity_trend_alert_unit.sv]
// Top level of the proximity trend alert unit: input register, core, result register.
// Depends on pta_pkg, pta_in_if, pta_out_if, pta_regs, pta_core and the macro header.
//
// Usage:
//   in_i  carries one position update per item (fix flag, time in ms, nearest
//         point id and distance, distance to the tracked point).
//   out_o carries one result item per input item: alert state, active flag,
//         repaint flag, tracked point, shown distance and buzzer tone.
//   The APB port writes and reads the seven configuration registers at byte
//   addresses 0, 4, ..., 24; pready is always high. Write only while idle.
// Timing:
//   An item is registered on acceptance and processed by the core in a cycle
//   in which the result register is empty or being read; its result is
//   registered at the end of that cycle, so out_o.valid rises in the cycle
//   after the step. One item per cycle is sustained while out_o.ready stays
//   high; the core computes each update combinationally.
// Reset clears the alert state, trend counters, timers and siren, loads the
//   register defaults and empties both pipeline registers.
// When the receiver stalls, the result is held, one more item is taken into
//   the input register, and then in_i.ready drops until the result is taken.
`default_nettype none
`include "proximity_trend_alert_unit_macros.svh"

module proximity_trend_alert_unit #(
  parameter int ID_BITS   = pta_pkg::ID_BITS_DEF,
  parameter int DIST_BITS = pta_pkg::DIST_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  pta_in_if.sink                                 in_i,
  pta_out_if.source                              out_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pta_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [pta_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [pta_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                   pready
);

  pta_pkg::pta_cfg_t cfg;

  // Input register
  logic                 in_vld_q;
  logic                 pos_q;
  logic [31:0]          now_q;
  logic                 found_q;
  logic [ID_BITS-1:0]   cid_q;
  logic [DIST_BITS-1:0] cdist_q;
  logic [DIST_BITS-1:0] tdist_q;

  // Result register
  logic                 out_vld_q;
  logic [1:0]           st_q;
  logic                 act_q;
  logic                 rst_need_q;
  logic                 tv_q;
  logic [ID_BITS-1:0]   tid_q;
  logic [DIST_BITS-1:0] shown_q;
  logic [2:0]           tone_q;

  // Core result of the current step
  logic [1:0]           st_c;
  logic                 act_c;
  logic                 rst_need_c;
  logic                 tv_c;
  logic [ID_BITS-1:0]   tid_c;
  logic [DIST_BITS-1:0] shown_c;
  logic [2:0]           tone_c;

  logic advance;
  logic take_in;

  assign advance    = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~in_vld_q | advance;
  assign take_in    = in_i.valid & in_i.ready;

  pta_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pta_core #(
    .ID_BITS   (ID_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .step_i               (advance),
    .cfg_i                (cfg),
    .position_valid_i     (pos_q),
    .now_ms_i             (now_q),
    .closest_found_i      (found_q),
    .closest_id_i         (cid_q),
    .closest_distance_m_i (cdist_q),
    .tracked_distance_m_i (tdist_q),
    .alert_state_o        (st_c),
    .alert_active_o       (act_c),
    .restore_needed_o     (rst_need_c),
    .tracked_valid_o      (tv_c),
    .tracked_id_o         (tid_c),
    .shown_distance_m_o   (shown_c),
    .tone_code_o          (tone_c)
  );

  // Input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take_in) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      pos_q   <= in_i.position_valid;
      now_q   <= in_i.now_ms;
      found_q <= in_i.closest_found;
      cid_q   <= in_i.closest_id;
      cdist_q <= in_i.closest_distance_m;
      tdist_q <= in_i.tracked_distance_m;
    end
  end

  // Result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      st_q       <= st_c;
      act_q      <= act_c;
      rst_need_q <= rst_need_c;
      tv_q       <= tv_c;
      tid_q      <= tid_c;
      shown_q    <= shown_c;
      tone_q     <= tone_c;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.alert_state      = st_q;
  assign out_o.alert_active     = act_q;
  assign out_o.restore_needed   = rst_need_q;
  assign out_o.tracked_valid    = tv_q;
  assign out_o.tracked_id       = tid_q;
  assign out_o.shown_distance_m = shown_q;
  assign out_o.tone_code        = tone_q;

  // Input is blocked only when both stages are full and the result is stalled
  `PTA_ASSERT_IMP(a_ready_low_full, clk_i, rst_ni, !in_i.ready,
                  in_vld_q && out_vld_q && !out_o.ready, "input blocked without backpressure")
  // A step always produces a result in the next cycle
  `PTA_ASSERT_NXT(a_step_gives_result, clk_i, rst_ni, advance, out_vld_q,
                  "step produced no result")
  // A repaint request comes only with a cleared, inactive alert
  `PTA_ASSERT_IMP(a_restore_inactive, clk_i, rst_ni, out_vld_q && rst_need_q,
                  st_q == pta_pkg::ST_INACTIVE && !act_q, "restore with alert still up")
  // A distance is only shown while the alert is active
  `PTA_ASSERT_IMP(a_shown_needs_active, clk_i, rst_ni, out_vld_q && shown_q != '0, act_q,
                  "distance shown while alert inactive")

endmodule

`default_nettype wire

[tb/sv/proximity_trend_alert_unit_tb.sv]
// Self-checking testbench for proximity_trend_alert_unit: directed and random position items,
// APB register programming with read-back, random input idling and result back-pressure.
// Depends on pta_pkg, pta_in_if, pta_out_if and the unit itself.
`timescale 1ns / 1ps

module proximity_trend_alert_unit_tb;
  import pta_pkg::*;

  localparam int ID_W   = ID_BITS_DEF;
  localparam int DIST_W = DIST_BITS_DEF;
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [DIST_W-1:0] FAR_DIST  =
    (FAR_START > 32'(DIST_MAX)) ? DIST_MAX : FAR_START[DIST_W-1:0];

  typedef struct packed {
    logic              position_valid;
    logic [31:0]       now_ms;
    logic              closest_found;
    logic [ID_W-1:0]   closest_id;
    logic [DIST_W-1:0] closest_distance_m;
    logic [DIST_W-1:0] tracked_distance_m;
  } pos_item_t;

  typedef struct packed {
    alert_state_e      alert_state;
    logic              alert_active;
    logic              restore_needed;
    logic              tracked_valid;
    logic [ID_W-1:0]   tracked_id;
    logic [DIST_W-1:0] shown_distance_m;
    tone_e             tone_code;
  } alert_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                     psel, penable, pwrite, pready;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata, prdata;

  pta_in_if  in_if ();
  pta_out_if out_if ();

  proximity_trend_alert_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shared run state
  alert_res_t pending_alerts[$];
  int         n_errors     = 0;
  int         rx_hold_left = 0;
  logic       steady_flow  = 1'b0;

  // Alert model state and its copy of the registers
  pta_cfg_t          cfg_model;
  alert_state_e      st_q;
  logic              trk_valid_q;
  logic [ID_W-1:0]   trk_id_q;
  logic [DIST_W-1:0] last_dist_q;
  logic [1:0]        near_cnt_q, far_cnt_q;
  logic [31:0]       change_ms_q, siren_ms_q, away_ms_q, tone_due_q;
  logic              siren_run_q;
  siren_step_e       siren_step_q;
  tone_e             tone_q;

  // Trip generator state
  logic [31:0]     trip_ms;
  logic [ID_W-1:0] trip_id;
  int              trip_dist, trip_dir;

  function automatic void log_error(input string what);
    n_errors++;
    if (n_errors <= 10) $display("%0d ns: %s", $time, what);
  endfunction

  function automatic void stop_siren();
    tone_q       = TONE_OFF;
    siren_run_q  = 1'b0;
    siren_step_q = SIREN_S0;
    tone_due_q   = '0;
  endfunction

  // Next alert result for one position item; updates the model state
  task automatic predict_alert(input pos_item_t it, output alert_res_t r);
    logic [DIST_W-1:0] check, step_dist, shown;
    logic [15:0]       radius;
    logic              active, restore;
    alert_state_e      ns;
    logic [31:0]       since;
    int                delta, eps;
    active  = 1'b0;
    restore = 1'b0;
    shown   = '0;
    if (!it.position_valid || !cfg_model.enable_bits[EN_ALARM] || !it.closest_found) begin
      // no nearest point leaves the siren running
      if (!(it.position_valid && cfg_model.enable_bits[EN_ALARM])) stop_siren();
      if (st_q != ST_INACTIVE) begin
        st_q        = ST_INACTIVE;
        trk_valid_q = 1'b0;
        restore     = 1'b1;
      end
      away_ms_q = '0;
    end else begin
      check  = trk_valid_q ? it.tracked_distance_m : it.closest_distance_m;
      radius = (st_q == ST_DEPART) ? cfg_model.depart_clear_m : cfg_model.alarm_distance_m;
      if (check > radius) begin
        // out of range: away timer, zero start time means not started
        if (away_ms_q == 0) away_ms_q = it.now_ms;
        since = it.now_ms - away_ms_q;
        if (since > cfg_model.clear_ms) begin
          if (st_q != ST_INACTIVE) begin
            st_q        = ST_INACTIVE;
            trk_valid_q = 1'b0;
            last_dist_q = FAR_DIST;
            restore     = 1'b1;
          end
          away_ms_q = '0;
        end else if (st_q != ST_INACTIVE && trk_valid_q) begin
          active = 1'b1;
          shown  = check;
        end
      end else begin
        away_ms_q = '0;
        if (st_q == ST_INACTIVE || !trk_valid_q) begin
          trk_valid_q = 1'b1;
          trk_id_q    = it.closest_id;
          step_dist   = it.closest_distance_m;
        end else begin
          step_dist = it.tracked_distance_m;
        end
        // trend counters
        delta = int'(step_dist) - int'(last_dist_q);
        eps   = int'(cfg_model.epsilon_m);
        if (delta <= -eps) begin
          if (near_cnt_q < COUNT_MAX) near_cnt_q++;
          far_cnt_q = '0;
        end else if (delta >= eps) begin
          if (far_cnt_q < COUNT_MAX) far_cnt_q++;
          near_cnt_q = '0;
        end
        ns = st_q;
        if (st_q == ST_APPROACH) begin
          if (far_cnt_q >= CONFIRM_COUNT) ns = ST_DEPART;
        end else if (st_q == ST_DEPART) begin
          if (near_cnt_q >= CONFIRM_COUNT) ns = ST_APPROACH;
        end else if (near_cnt_q >= CONFIRM_COUNT) begin
          ns = ST_APPROACH;
        end else if (far_cnt_q >= CONFIRM_COUNT) begin
          ns = ST_DEPART;
        end
        // hold time gates changes out of an active state
        since = it.now_ms - change_ms_q;
        if (ns != st_q && (st_q == ST_INACTIVE || since >= cfg_model.hold_ms)) begin
          st_q        = ns;
          change_ms_q = it.now_ms;
          near_cnt_q  = '0;
          far_cnt_q   = '0;
          if (ns != ST_APPROACH) stop_siren();
        end
        active = 1'b1;
        shown  = step_dist;
        // siren restart; with the beeper off only the restart time moves
        since = it.now_ms - siren_ms_q;
        if (cfg_model.enable_bits[EN_SIREN] && st_q == ST_APPROACH &&
            since >= cfg_model.siren_gap_ms) begin
          if (cfg_model.enable_bits[EN_BEEPER]) begin
            siren_run_q  = 1'b1;
            siren_step_q = SIREN_S0;
            tone_due_q   = it.now_ms + STEP_SHORT_MS;
            tone_q       = TONE_600;
          end
          siren_ms_q = it.now_ms;
        end
        // siren step is due once now minus due time is below 2^31
        since = it.now_ms - tone_due_q;
        if (siren_run_q && !since[31]) begin
          case (siren_step_q)
            SIREN_S0: begin
              tone_q = TONE_900;  siren_step_q = SIREN_S1; tone_due_q = it.now_ms + STEP_SHORT_MS;
            end
            SIREN_S1: begin
              tone_q = TONE_1300; siren_step_q = SIREN_S2; tone_due_q = it.now_ms + STEP_SHORT_MS;
            end
            SIREN_S2: begin
              tone_q = TONE_1800; siren_step_q = SIREN_S3; tone_due_q = it.now_ms + STEP_LONG_MS;
            end
            default: stop_siren();
          endcase
        end
        last_dist_q = step_dist;
      end
    end
    r.alert_state      = st_q;
    r.alert_active     = active;
    r.restore_needed   = restore;
    r.tracked_valid    = trk_valid_q;
    r.tracked_id       = trk_id_q;
    r.shown_distance_m = shown;
    r.tone_code        = tone_q;
  endtask

  // Offer one item, wait for acceptance, then queue its predicted result
  task automatic send_position(input pos_item_t it);
    alert_res_t want;
    while (!steady_flow && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid              <= 1'b1;
    in_if.position_valid     <= it.position_valid;
    in_if.now_ms             <= it.now_ms;
    in_if.closest_found      <= it.closest_found;
    in_if.closest_id         <= it.closest_id;
    in_if.closest_distance_m <= it.closest_distance_m;
    in_if.tracked_distance_m <= it.tracked_distance_m;
    do @(posedge clk_i); while (!in_if.ready);
    predict_alert(it, want);
    pending_alerts.push_back(want);
  endtask

  task automatic send_fix(input bit pos, input logic [31:0] now, input bit found,
                          input int id, input int cdist, input int tdist);
    pos_item_t it;
    it.position_valid     = pos;
    it.now_ms             = now;
    it.closest_found      = found;
    it.closest_id         = ID_W'(id);
    it.closest_distance_m = DIST_W'(cdist);
    it.tracked_distance_m = DIST_W'(tdist);
    send_position(it);
  endtask

  // Drop valid and wait, bounded, until every result has come back
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    for (int w = 0; w < 4000 && pending_alerts.size() > 0; w++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write, then read the register back
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    logic [31:0] kept;
    case (idx)
      REG_ALARM_DIST: begin cfg_model.alarm_distance_m = val[15:0]; kept = {16'b0, val[15:0]}; end
      REG_DEPART_CLR: begin cfg_model.depart_clear_m = val[15:0]; kept = {16'b0, val[15:0]}; end
      REG_EPSILON:    begin cfg_model.epsilon_m = val[9:0]; kept = {22'b0, val[9:0]}; end
      REG_HOLD:       begin cfg_model.hold_ms = val; kept = val; end
      REG_CLEAR:      begin cfg_model.clear_ms = val; kept = val; end
      REG_SIREN_IVL:  begin cfg_model.siren_gap_ms = val; kept = val; end
      REG_ENABLE:     begin cfg_model.enable_bits = val[2:0]; kept = {29'b0, val[2:0]}; end
      default:        kept = '0;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // write lands at this edge; turn straight into a read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== kept)
      log_error($sformatf("register %s read back %h, wrote %h", idx.name(), prdata, kept));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_config(input pta_cfg_t c);
    settle_idle();
    write_reg(REG_ALARM_DIST, {16'b0, c.alarm_distance_m});
    write_reg(REG_DEPART_CLR, {16'b0, c.depart_clear_m});
    write_reg(REG_EPSILON, {22'b0, c.epsilon_m});
    write_reg(REG_HOLD, c.hold_ms);
    write_reg(REG_CLEAR, c.clear_ms);
    write_reg(REG_SIREN_IVL, c.siren_gap_ms);
    write_reg(REG_ENABLE, {29'b0, c.enable_bits});
  endtask

  // Random drives: approach/depart walks around the alarm radius, plus noise
  task automatic run_trips(input int n_items, input logic [31:0] start_ms);
    pos_item_t it;
    int        span, eps, roll;
    span      = int'(cfg_model.alarm_distance_m) + 400;
    eps       = int'(cfg_model.epsilon_m);
    trip_ms   = start_ms;
    trip_id   = ID_W'($urandom);
    trip_dist = span;
    trip_dir  = -1;
    repeat (n_items) begin
      trip_ms = trip_ms + (($urandom_range(99) < 80) ? 32'($urandom_range(0, 300))
                                                     : 32'($urandom_range(300, 4000)));
      if ($urandom_range(99) < 10) trip_dir = -trip_dir;
      trip_dist += trip_dir * int'($urandom_range(0, 2 * eps + 30));
      if (trip_dist < 0) begin
        trip_dist = 0;
        trip_dir  = 1;
      end else if (trip_dist > span) begin
        trip_dist = span;
        trip_dir  = -1;
      end
      if ($urandom_range(199) == 0) begin
        trip_id   = ID_W'($urandom);
        trip_dist = span;
        trip_dir  = -1;
      end
      it.position_valid     = 1'b1;
      it.now_ms             = trip_ms;
      it.closest_found      = 1'b1;
      it.closest_id         = trip_id;
      it.closest_distance_m = DIST_W'(trip_dist);
      it.tracked_distance_m = DIST_W'(trip_dist);
      roll = $urandom_range(99);
      if (roll < 6) begin
        it.position_valid     = 1'($urandom_range(1));
        it.now_ms             = $urandom;
        it.closest_found      = 1'($urandom_range(1));
        it.closest_id         = ID_W'($urandom);
        it.closest_distance_m = DIST_W'($urandom);
        it.tracked_distance_m = DIST_W'($urandom);
      end else if (roll < 10) begin
        it.position_valid = 1'b0;
      end else if (roll < 13) begin
        it.closest_found = 1'b0;
      end else if (roll < 20) begin
        // another point is closer than the tracked one
        it.closest_id         = ID_W'($urandom);
        it.closest_distance_m = DIST_W'($urandom_range(0, trip_dist));
      end else if (roll < 25) begin
        it.tracked_distance_m = DIST_W'(trip_dist + int'($urandom_range(0, 50)));
      end
      send_position(it);
    end
  endtask

  // Hand-built walk through the state machine under reset settings
  task automatic test_directed_defaults();
    send_fix(0, 32'd20000, 1, 7, 100, 100);            // no fix
    send_fix(1, 32'd20100, 0, 7, 100, 100);            // no nearest point
    send_fix(1, 32'd20200, 1, 1023, 1048575, 0);       // saturated distance, away timer starts
    send_fix(1, 32'd0, 1, 0, 600, 0);                  // time wrapped, timed out
    send_fix(1, 32'd0, 1, 0, 700, 0);                  // away timer started at time zero
    send_fix(1, 32'd100, 1, 0, 700, 0);
    send_fix(1, 32'd30000, 1, 12, 480, 480);           // start tracking
    send_fix(1, 32'd30100, 1, 12, 460, 460);           // approach confirmed, siren on
    send_fix(1, 32'd30220, 1, 999, 50, 440);           // tracked distance differs from closest
    send_fix(1, 32'd30340, 1, 999, 60, 430);
    send_fix(1, 32'd30460, 1, 12, 425, 425);
    send_fix(1, 32'd30600, 1, 12, 430, 430);           // siren sequence ends
    send_fix(1, 32'd30700, 1, 12, 450, 450);
    send_fix(1, 32'd30800, 1, 12, 470, 470);           // depart held off
    send_fix(1, 32'd32200, 1, 12, 490, 490);           // depart after hold
    send_fix(1, 32'd32300, 1, 12, 550, 550);           // inside the wider exit radius
    send_fix(1, 32'd32400, 1, 12, 650, 1048575);       // out of range, still shown
    send_fix(1, 32'd34000, 1, 12, 700, 700);
    send_fix(1, 32'd35500, 1, 12, 700, 700);           // cleared after timeout
    send_fix(1, 32'd35600, 1, 512, 300, 300);
    send_fix(1, 32'd35700, 1, 512, 280, 280);          // approach inside siren interval
    send_fix(1, 32'd35800, 0, 512, 280, 280);          // nearest lost while active
    send_fix(1, 32'd35900, 1, 512, 250, 250);
    send_fix(0, 32'hFFFF_FFFF, 1, 512, 0, 0);          // fix lost
  endtask

  task automatic test_default_trips();
    run_trips(400, 32'hFFFF_0000);                     // runs across the time wrap
  endtask

  // Widest radius, zero thresholds and timers
  task automatic test_loose_extremes();
    pta_cfg_t c;
    c = '{alarm_distance_m: 16'hFFFF, depart_clear_m: 16'h0, epsilon_m: 10'h0,
          hold_ms: 32'h0, clear_ms: 32'h0, siren_gap_ms: 32'h0, enable_bits: 3'b111};
    program_config(c);
    run_trips(120, trip_ms);
  endtask

  // Zero radius, largest thresholds and timers, beeper off
  task automatic test_tight_extremes();
    pta_cfg_t c;
    c = '{alarm_distance_m: 16'h0, depart_clear_m: 16'hFFFF, epsilon_m: 10'h3FF,
          hold_ms: '1, clear_ms: '1, siren_gap_ms: '1, enable_bits: 3'b011};
    program_config(c);
    run_trips(120, trip_ms);
  endtask

  // Every enable combination with random mid-range settings
  task automatic test_enable_rounds();
    pta_cfg_t c;
    for (int en = 0; en < 8; en++) begin
      c.alarm_distance_m = 16'($urandom_range(200, 3000));
      c.depart_clear_m   = c.alarm_distance_m + 16'($urandom_range(0, 400));
      c.epsilon_m        = 10'($urandom_range(0, 40));
      c.hold_ms          = $urandom_range(0, 3000);
      c.clear_ms         = $urandom_range(0, 5000);
      c.siren_gap_ms     = $urandom_range(0, 5000);
      c.enable_bits      = 3'(en);
      program_config(c);
      run_trips(120, trip_ms);
    end
  endtask

  // Back to reset values, both sides without idle cycles
  task automatic test_steady_stream();
    pta_cfg_t c;
    c = '{alarm_distance_m: ALARM_DIST_RST, depart_clear_m: DEPART_CLR_RST,
          epsilon_m: EPSILON_RST, hold_ms: HOLD_RST, clear_ms: CLEAR_RST,
          siren_gap_ms: SIREN_IVL_RST, enable_bits: ENABLE_RST};
    program_config(c);
    steady_flow = 1'b1;
    run_trips(300, trip_ms);
    steady_flow = 1'b0;
  endtask

  // Receiver holds off while items keep coming, then the sender drains
  task automatic test_backpressure();
    steady_flow  = 1'b1;
    rx_hold_left = 100;
    run_trips(40, trip_ms);
    steady_flow  = 1'b0;
    settle_idle();
  endtask

  // Result receiver: random stalls, forced hold-off when requested
  initial begin : result_sink
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        out_if.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_if.ready <= steady_flow || ($urandom_range(99) >= 13);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    alert_res_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.alert_state      = alert_state_e'(out_if.alert_state);
      got.alert_active     = out_if.alert_active;
      got.restore_needed   = out_if.restore_needed;
      got.tracked_valid    = out_if.tracked_valid;
      got.tracked_id       = out_if.tracked_id;
      got.shown_distance_m = out_if.shown_distance_m;
      got.tone_code        = tone_e'(out_if.tone_code);
      if (pending_alerts.size() == 0) begin
        log_error("result with no item outstanding");
      end else begin
        want = pending_alerts.pop_front();
        if (got.alert_state !== want.alert_state || got.alert_active !== want.alert_active ||
            got.restore_needed !== want.restore_needed ||
            got.tracked_valid !== want.tracked_valid || got.tracked_id !== want.tracked_id ||
            got.shown_distance_m !== want.shown_distance_m ||
            got.tone_code !== want.tone_code)
          log_error($sformatf({"mismatch st/act/rst/tv/id/dist/tone exp %0d %b %b %b %0d %0d %0d",
                               " got %0d %b %b %b %0d %0d %0d"},
                              want.alert_state, want.alert_active, want.restore_needed,
                              want.tracked_valid, want.tracked_id, want.shown_distance_m,
                              want.tone_code, got.alert_state, got.alert_active,
                              got.restore_needed, got.tracked_valid, got.tracked_id,
                              got.shown_distance_m, got.tone_code));
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("proximity_trend_alert_unit_tb: errors");
    $finish;
  end

  initial begin : test_sequence
    rst_ni                   = 1'b0;
    in_if.valid              <= 1'b0;
    in_if.position_valid     <= 1'b0;
    in_if.now_ms             <= '0;
    in_if.closest_found      <= 1'b0;
    in_if.closest_id         <= '0;
    in_if.closest_distance_m <= '0;
    in_if.tracked_distance_m <= '0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    // model reset state
    cfg_model = '{alarm_distance_m: ALARM_DIST_RST, depart_clear_m: DEPART_CLR_RST,
                  epsilon_m: EPSILON_RST, hold_ms: HOLD_RST, clear_ms: CLEAR_RST,
                  siren_gap_ms: SIREN_IVL_RST, enable_bits: ENABLE_RST};
    st_q        = ST_INACTIVE;
    trk_valid_q = 1'b0;
    trk_id_q    = '0;
    last_dist_q = FAR_DIST;
    near_cnt_q  = '0;
    far_cnt_q   = '0;
    change_ms_q = '0;
    siren_ms_q  = '0;
    away_ms_q   = '0;
    stop_siren();
    trip_ms     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_default_trips();
    test_loose_extremes();
    test_tight_extremes();
    test_enable_rounds();
    test_steady_stream();
    test_backpressure();

    settle_idle();
    if (pending_alerts.size() > 0)
      log_error($sformatf("%0d results never arrived", pending_alerts.size()));
    if (n_errors == 0) begin
      $display("proximity_trend_alert_unit_tb: clean");
    end else begin
      $display("proximity_trend_alert_unit_tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/pta_pkg.sv
sv/pta_in_if.sv
sv/pta_out_if.sv
sv/pta_regs.sv
sv/pta_core.sv
sv/proximity_trend_alert_unit.sv
tb/sv/proximity_trend_alert_unit_tb.sv
